FILE: hw/rtl/feal_pkg.sv
// Shared types, register codes and round functions of the FEAL-N cipher.
`timescale 1ns / 1ps

package feal_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROUNDS   = 2'd2;

  localparam logic [5:0] ROUNDS_RESET = 6'd8;

  typedef enum logic {
    ST_IDLE,
    ST_ROUND
  } feal_state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] key_high;
    logic [31:0] key_low;
  } ks_req_t;

  // Whitening subkeys N..N+7.
  typedef logic [7:0][15:0] wkey_t;

  function automatic logic [7:0] sbox(input logic [7:0] a, input logic [7:0] b,
                                      input logic d);
    logic [7:0] t;
    t = a + b + {7'b0, d};
    return {t[5:0], t[7:6]};
  endfunction

  function automatic logic [31:0] f_func(input logic [31:0] a, input logic [15:0] k);
    logic [7:0] s1, s2, u0, u1, u2, u3;
    s1 = a[31:24] ^ a[23:16] ^ k[15:8];
    s2 = a[15:8] ^ a[7:0] ^ k[7:0];
    u1 = sbox(s1, s2, 1'b1);
    u2 = sbox(s2, u1, 1'b0);
    u0 = sbox(a[31:24], u1, 1'b0);
    u3 = sbox(a[7:0], u2, 1'b1);
    return {u0, u1, u2, u3};
  endfunction

  function automatic logic [31:0] fk_func(input logic [31:0] a, input logic [31:0] b);
    logic [7:0] s1, s2, u0, u1, u2, u3;
    s1 = a[31:24] ^ a[23:16];
    s2 = a[15:8] ^ a[7:0];
    u1 = sbox(s1, s2 ^ b[31:24], 1'b1);
    u2 = sbox(s2, u1 ^ b[23:16], 1'b0);
    u0 = sbox(a[31:24], u1 ^ b[15:8], 1'b0);
    u3 = sbox(a[7:0], u2 ^ b[7:0], 1'b1);
    return {u0, u1, u2, u3};
  endfunction

endpackage

FILE: hw/rtl/feal_keysched.sv
// Key schedule sequencer and subkey memory of the FEAL-N cipher.
`timescale 1ns / 1ps

module feal_keysched #(
  parameter int unsigned MAX_ROUNDS = 32,
  parameter int unsigned NW = $clog2(MAX_ROUNDS + 1),
  parameter int unsigned AW = $clog2(MAX_ROUNDS + 9)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  feal_pkg::ks_req_t req_i,
  input  logic [NW-1:0]    n_i,
  output logic             busy_o,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [15:0]      rd_data_o,
  output feal_pkg::wkey_t  wkey_o
);
  import feal_pkg::*;

  localparam int unsigned Depth = MAX_ROUNDS + 9;

  logic [15:0] mem [Depth];
  logic [15:0] rd_data_q;

  logic          busy_q, busy_d;
  logic          phase_q, phase_d;
  logic [AW-1:0] waddr_q, waddr_d;
  logic [31:0]   a_q, a_d, b_q, b_d, d_q, d_d, nb_q, nb_d;
  wkey_t         wkey_q;

  logic [31:0]   nb;
  logic [15:0]   wdata;
  logic [AW-1:0] last_addr, diff;
  logic          wk_hit;

  assign nb        = fk_func(a_q, b_q ^ d_q);
  assign wdata     = phase_q ? nb_q[15:0] : nb[31:16];
  assign last_addr = AW'(n_i) + AW'(7) + AW'(n_i[0]);
  assign diff      = waddr_q - AW'(n_i);
  assign wk_hit    = busy_q && (waddr_q >= AW'(n_i)) && (diff < AW'(8));

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    waddr_d = waddr_q;
    a_d     = a_q;
    b_d     = b_q;
    d_d     = d_q;
    nb_d    = nb_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      waddr_d = '0;
      a_d     = req_i.key_high;
      b_d     = req_i.key_low;
      d_d     = '0;
    end else if (busy_q) begin
      waddr_d = waddr_q + AW'(1);
      phase_d = ~phase_q;
      if (!phase_q) begin
        nb_d = nb;
      end else begin
        d_d = a_q;
        a_d = b_q;
        b_d = nb_q;
        if (waddr_q == last_addr) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      phase_q <= 1'b0;
      waddr_q <= '0;
      a_q     <= '0;
      b_q     <= '0;
      d_q     <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      waddr_q <= waddr_d;
      a_q     <= a_d;
      b_q     <= b_d;
      d_q     <= d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nb_q <= nb_d;
    if (wk_hit) begin
      wkey_q[diff[2:0]] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[waddr_q] <= wdata;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign busy_o    = busy_q;
  assign rd_data_o = rd_data_q;
  assign wkey_o    = wkey_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q && waddr_q == '0)
    else $error("schedule did not restart");

  a_addr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start && phase_q && waddr_q == last_addr |=> !busy_q)
    else $error("schedule ran past its last subkey");

endmodule

FILE: hw/rtl/feal_n_block_cipher.sv
// Top level of the FEAL-N block cipher: config registers, round datapath, output register.
//
//  channel | direction | handshake             | beat
//  --------+-----------+-----------------------+--------------------------------------
//  cfg     | in        | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o | operation_i, block_high_i, block_low_i
//  out     | out       | out_valid_o/ready_i   | out_high_o, out_low_o
//
// The accept cycle of a block applies input whitening and reads the first subkey, then
// one f round per cycle follows, each fed by the subkey read in the cycle before from
// the single-read-port store; the last round also applies output whitening.
// After reset and after each register write the key schedule fills the store (two
// subkeys per fK step, one write port); no beat is taken meanwhile.
// A result waiting on out_ready_i holds the last round; the next beat is taken once the
// round loop is free, while the previous result still waits.
`timescale 1ns / 1ps

module feal_n_block_cipher #(
  parameter int unsigned MAX_ROUNDS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [feal_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         operation_i,
  input  logic [31:0]                  block_high_i,
  input  logic [31:0]                  block_low_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [31:0]                  out_high_o,
  output logic [31:0]                  out_low_o
);
  import feal_pkg::*;

  localparam int unsigned NW = $clog2(MAX_ROUNDS + 1);
  localparam int unsigned AW = $clog2(MAX_ROUNDS + 9);

  feal_state_e state_q, state_d;

  logic [31:0] key_high_q, key_high_d, key_low_q, key_low_d;
  logic [5:0]  rounds_q, rounds_d;
  logic [NW-1:0] n;

  ks_req_t       ks_req;
  logic          ks_busy;
  logic [15:0]   subkey;
  wkey_t         wkey;

  logic          op_q, op_d;
  logic [31:0]   l_q, l_d, r_q, r_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;

  logic          out_valid_q, out_load;
  logic [31:0]   out_high_q, out_low_q, out_high_d, out_low_d;

  logic          cfg_we, in_fire, last;
  logic [31:0]   kp0, kp2, kp4, kp6, f_res, nl, nr;

  // effective round count
  always_comb begin
    if (rounds_q == '0) begin
      n = NW'(1);
    end else if (int'(rounds_q) > MAX_ROUNDS) begin
      n = NW'(MAX_ROUNDS);
    end else begin
      n = NW'(rounds_q);
    end
  end

  // a pending config beat goes first
  assign cfg_ready_o = (state_q == ST_IDLE) && !ks_busy;
  assign in_ready_o  = cfg_ready_o && !cfg_valid_i;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    key_high_d   = key_high_q;
    key_low_d    = key_low_q;
    rounds_d     = rounds_q;
    ks_req.start = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_KEY_HIGH: key_high_d = cfg_data_i;
        CFG_KEY_LOW:  key_low_d  = cfg_data_i;
        CFG_ROUNDS:   rounds_d   = cfg_data_i[5:0];
        default: ;
      endcase
      ks_req.start = cfg_index_i inside {CFG_KEY_HIGH, CFG_KEY_LOW, CFG_ROUNDS};
    end
    ks_req.key_high = key_high_d;
    ks_req.key_low  = key_low_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      rounds_q   <= ROUNDS_RESET;
    end else begin
      key_high_q <= key_high_d;
      key_low_q  <= key_low_d;
      rounds_q   <= rounds_d;
    end
  end

  feal_keysched #(
    .MAX_ROUNDS(MAX_ROUNDS),
    .NW        (NW),
    .AW        (AW)
  ) u_keysched (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (ks_req),
    .n_i      (n),
    .busy_o   (ks_busy),
    .rd_addr_i(idx_d),
    .rd_data_o(subkey),
    .wkey_o   (wkey)
  );

  assign kp0 = {wkey[0], wkey[1]};
  assign kp2 = {wkey[2], wkey[3]};
  assign kp4 = {wkey[4], wkey[5]};
  assign kp6 = {wkey[6], wkey[7]};

  assign f_res = f_func(op_q ? l_q : r_q, subkey);
  assign nl    = op_q ? (r_q ^ f_res) : r_q;
  assign nr    = op_q ? l_q : (l_q ^ f_res);
  assign last  = cnt_q == (n - NW'(1));

  always_comb begin
    if (op_q) begin
      out_high_d = nl ^ kp0;
      out_low_d  = nr ^ nl ^ kp2;
    end else begin
      out_high_d = nr ^ kp4;
      out_low_d  = nl ^ nr ^ kp6;
    end
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    l_d      = l_q;
    r_d      = r_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d    = operation_i;
          cnt_d   = '0;
          state_d = ST_ROUND;
          if (operation_i) begin
            r_d   = block_high_i ^ kp4;
            l_d   = block_low_i ^ kp6 ^ block_high_i ^ kp4;
            idx_d = AW'(n) - AW'(1);
          end else begin
            l_d   = block_high_i ^ kp0;
            r_d   = block_low_i ^ kp2 ^ block_high_i ^ kp0;
            idx_d = '0;
          end
        end
      end
      ST_ROUND: begin
        if (!last) begin
          l_d   = nl;
          r_d   = nr;
          cnt_d = cnt_q + NW'(1);
          idx_d = op_q ? (idx_q - AW'(1)) : (idx_q + AW'(1));
        end else if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_d_reg: begin
      op_q  <= op_d;
      l_q   <= l_d;
      r_q   <= r_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
    if (out_load) begin
      out_high_q <= out_high_d;
      out_low_q  <= out_low_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_high_o  = out_high_q;
  assign out_low_o   = out_low_q;

  a_no_beat_in_schedule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !ks_busy && !ks_req.start)
    else $error("beat taken while subkeys are being written");

  a_accept_starts_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_ROUND && cnt_q == '0)
    else $error("accepted beat did not enter the round loop");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !out_load)
    else $error("result overwritten before it was taken");

  a_round_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND && !last |=> state_q == ST_ROUND && !cfg_ready_o)
    else $error("round loop left early");

endmodule

FILE: bench/tb_feal_n_block_cipher.sv
// Self-checking testbench for the FEAL-N block cipher: directed table, random traffic, predictor.
`timescale 1ns / 1ps

module tb_feal_n_block_cipher;
  import feal_pkg::*;

  localparam int unsigned MAX_N      = 32;
  localparam int unsigned KEY_DEPTH  = MAX_N + 9;
  localparam int unsigned STALL_MAX  = 2000;
  localparam int unsigned DRAIN_WAIT = MAX_N + 8;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  // first an index with no register behind it, then the don't-care index of block rows
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam logic [CfgIdxW-1:0] IDX_NONE   = CFG_KEY_HIGH;

  typedef struct packed {
    logic [31:0] hi;
    logic [31:0] lo;
  } block_t;

  typedef enum logic {
    ROW_CFG,
    ROW_BLOCK
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic               op;
    logic [31:0]        a;
    logic [31:0]        b;
    logic               typed;
    logic [31:0]        exp_hi;
    logic [31:0]        exp_lo;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               operation_i;
  logic [31:0]        block_high_i;
  logic [31:0]        block_low_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [31:0]        out_high_o;
  logic [31:0]        out_low_o;

  feal_n_block_cipher #(
    .MAX_ROUNDS(MAX_N)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .block_high_i(block_high_i),
    .block_low_i (block_low_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_high_o  (out_high_o),
    .out_low_o   (out_low_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- cipher predictor
  logic [31:0] cur_key_high;
  logic [31:0] cur_key_low;
  logic [5:0]  cur_rounds;
  logic [15:0] sub_keys [KEY_DEPTH];

  block_t expected_q [$];
  int     fail_count  = 0;
  int     tx_idle_pct = 14;
  int     rx_idle_pct = 66;
  int     stall_cycles = 0;
  block_t res_want;

  function automatic int eff_rounds();
    if (cur_rounds == 6'd0) return 1;
    if (cur_rounds > MAX_N) return MAX_N;
    return int'(cur_rounds);
  endfunction

  // add with carry-in, mod 256, rotate left 2
  function automatic logic [7:0] s_mix(input logic [7:0] a, input logic [7:0] b,
                                       input logic d);
    logic [7:0] t;
    t = a + b + 8'(d);
    return {t[5:0], t[7:6]};
  endfunction

  function automatic logic [31:0] round_f(input logic [31:0] x, input logic [15:0] k);
    logic [7:0] t1, t2, y0, y1, y2, y3;
    t1 = x[31:24] ^ x[23:16] ^ k[15:8];
    t2 = x[15:8] ^ x[7:0] ^ k[7:0];
    y1 = s_mix(t1, t2, 1'b1);
    y2 = s_mix(t2, y1, 1'b0);
    y0 = s_mix(x[31:24], y1, 1'b0);
    y3 = s_mix(x[7:0], y2, 1'b1);
    return {y0, y1, y2, y3};
  endfunction

  function automatic logic [31:0] sched_f(input logic [31:0] x, input logic [31:0] y);
    logic [7:0] t1, t2, y0, y1, y2, y3;
    t1 = x[31:24] ^ x[23:16];
    t2 = x[15:8] ^ x[7:0];
    y1 = s_mix(t1, t2 ^ y[31:24], 1'b1);
    y2 = s_mix(t2, y1 ^ y[23:16], 1'b0);
    y0 = s_mix(x[31:24], y1 ^ y[15:8], 1'b0);
    y3 = s_mix(x[7:0], y2 ^ y[7:0], 1'b1);
    return {y0, y1, y2, y3};
  endfunction

  function automatic void expand_schedule();
    int          steps;
    logic [31:0] ka, kb, kd, nxt;
    steps = (eff_rounds() + 9) / 2;
    ka = cur_key_high;
    kb = cur_key_low;
    kd = '0;
    foreach (sub_keys[i]) sub_keys[i] = '0;
    for (int s = 0; s < steps; s++) begin
      nxt = sched_f(ka, kb ^ kd);
      kd  = ka;
      ka  = kb;
      kb  = nxt;
      if (2 * s + 1 < KEY_DEPTH) begin
        sub_keys[2 * s]     = nxt[31:16];
        sub_keys[2 * s + 1] = nxt[15:0];
      end
    end
  endfunction

  function automatic logic [31:0] key_pair(input int i);
    return {sub_keys[i % KEY_DEPTH], sub_keys[(i + 1) % KEY_DEPTH]};
  endfunction

  function automatic void apply_cfg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_KEY_HIGH: cur_key_high = data;
      CFG_KEY_LOW:  cur_key_low  = data;
      CFG_ROUNDS:   cur_rounds   = data[5:0];
      default:      return;
    endcase
    expand_schedule();
  endfunction

  function automatic block_t cipher_block(input logic op, input logic [31:0] hi,
                                          input logic [31:0] lo);
    int          n;
    logic [31:0] l, r, t;
    n = eff_rounds();
    if (op == OP_ENC) begin
      l = hi ^ key_pair(n);
      r = lo ^ key_pair(n + 2) ^ l;
      for (int i = 0; i < n; i++) begin
        t = l ^ round_f(r, sub_keys[i]);
        l = r;
        r = t;
      end
      l = l ^ r ^ key_pair(n + 6);
      r = r ^ key_pair(n + 4);
      return '{hi: r, lo: l};
    end else begin
      r = hi ^ key_pair(n + 4);
      l = lo ^ key_pair(n + 6) ^ r;
      for (int i = n; i >= 1; i--) begin
        t = r ^ round_f(l, sub_keys[i - 1]);
        r = l;
        l = t;
      end
      r = r ^ l ^ key_pair(n + 2);
      l = l ^ key_pair(n);
      return '{hi: l, lo: r};
    end
  endfunction

  // ---------------------------------------------------------------- drivers
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_cfg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic send_block(input logic op, input logic [31:0] hi, input logic [31:0] lo,
                            input logic typed, input block_t typed_res);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    block_high_i <= hi;
    block_low_i  <= lo;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(typed ? typed_res : cipher_block(op, hi, lo));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic random_config();
    logic [5:0]  n_pick;
    logic [31:0] w;
    cfg_write(CFG_KEY_HIGH, rand_word());
    cfg_write(CFG_KEY_LOW, rand_word());
    if ($urandom_range(3) == 0) cfg_write(CFG_UNUSED, $urandom);
    case ($urandom_range(9))
      0:       n_pick = 6'd0;
      1:       n_pick = 6'd1;
      2:       n_pick = 6'(MAX_N);
      3:       n_pick = 6'($urandom_range(63, MAX_N + 1));
      default: n_pick = 6'($urandom_range(12, 2));
    endcase
    w = $urandom;
    cfg_write(CFG_ROUNDS, {w[31:6], n_pick});
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= rx_idle_pct);

  // ---------------------------------------------------------------- checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: out_high %h out_low %h",
               out_high_o, out_low_o);
        fail_count++;
      end else begin
        res_want = expected_q.pop_front();
        if (out_high_o !== res_want.hi) begin
          $error("out_high: expected %h, got %h", res_want.hi, out_high_o);
          fail_count++;
        end
        if (out_low_o !== res_want.lo) begin
          $error("out_low: expected %h, got %h", res_want.lo, out_low_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  dir_row_t dir_rows [26] = '{
    '{ROW_BLOCK, IDX_NONE,     OP_ENC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_BLOCK, IDX_NONE,     OP_DEC, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0, 32'h0},
    '{ROW_BLOCK, IDX_NONE,     OP_ENC, 32'hffff_ffff, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_BLOCK, IDX_NONE,     OP_DEC, 32'h0000_0000, 32'hffff_ffff, 1'b0, 32'h0, 32'h0},
    '{ROW_CFG,   CFG_KEY_HIGH, OP_ENC, 32'h0123_4567, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_CFG,   CFG_KEY_LOW,  OP_ENC, 32'h89ab_cdef, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    // published FEAL-8 vector, both directions
    '{ROW_BLOCK, IDX_NONE,     OP_ENC, 32'h0000_0000, 32'h0000_0000, 1'b1,
      32'hceef_2c86, 32'hf249_0752},
    '{ROW_BLOCK, IDX_NONE,     OP_DEC, 32'hceef_2c86, 32'hf249_0752, 1'b1,
      32'h0000_0000, 32'h0000_0000},
    // zero rounds runs as one
    '{ROW_CFG,   CFG_ROUNDS,   OP_ENC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_BLOCK, IDX_NONE,     OP_ENC, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 1'b0, 32'h0, 32'h0},
    '{ROW_BLOCK, IDX_NONE,     OP_DEC, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 1'b0, 32'h0, 32'h0},
    // above the build limit saturates
    '{ROW_CFG,   CFG_ROUNDS,   OP_ENC, 32'h0000_003f, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_BLOCK, IDX_NONE,     OP_ENC, 32'h0000_0000, 32'hffff_ffff, 1'b0, 32'h0, 32'h0},
    '{ROW_BLOCK, IDX_NONE,     OP_DEC, 32'hffff_ffff, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_CFG,   CFG_ROUNDS,   OP_ENC, 32'h0000_0020, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_BLOCK, IDX_NONE,     OP_ENC, 32'h1234_5678, 32'h9abc_def0, 1'b0, 32'h0, 32'h0},
    '{ROW_CFG,   CFG_ROUNDS,   OP_ENC, 32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_BLOCK, IDX_NONE,     OP_DEC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    // no register at this index
    '{ROW_CFG,   CFG_UNUSED,   OP_ENC, 32'hffff_ffff, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_BLOCK, IDX_NONE,     OP_ENC, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0, 32'h0},
    // upper data bits dropped, odd round count
    '{ROW_CFG,   CFG_ROUNDS,   OP_ENC, 32'hffff_ffc7, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_BLOCK, IDX_NONE,     OP_ENC, 32'h8000_0000, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
    '{ROW_BLOCK, IDX_NONE,     OP_DEC, 32'h0000_0001, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_CFG,   CFG_KEY_HIGH, OP_ENC, 32'hffff_ffff, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_CFG,   CFG_KEY_LOW,  OP_ENC, 32'hffff_ffff, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_BLOCK, IDX_NONE,     OP_ENC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0}
  };

  initial begin
    dir_row_t row;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = IDX_NONE;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    operation_i  = OP_ENC;
    block_high_i = '0;
    block_low_i  = '0;
    out_ready_i  = 1'b0;
    cur_key_high = '0;
    cur_key_low  = '0;
    cur_rounds   = ROUNDS_RESET;
    expand_schedule();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        drain_results();
        cfg_write(row.idx, row.a);
        cfg_valid_i <= 1'b0;
      end else begin
        send_block(row.op, row.a, row.b, row.typed, '{hi: row.exp_hi, lo: row.exp_lo});
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 14;
          rx_idle_pct = 66;
        end
        1: begin
          tx_idle_pct = 66;
          rx_idle_pct = 14;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 4; s++) begin
        drain_results();
        random_config();
        cfg_valid_i <= 1'b0;
        for (int k = 0; k < 120; k++) begin
          // hold off until the pipe is empty
          if (s == 0 && k == 60) drain_results();
          send_block(1'($urandom_range(1)), rand_word(), rand_word(), 1'b0, '0);
        end
      end
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
